// ----- design/kcc_pkg.sv -----
package kcc_pkg;

  // Width of the millisecond time stamp and of all time differences.
  localparam int TimeBits = 32;

  // Widths of the configuration registers.
  localparam int HoldBits = 16;
  localparam int RptBits  = 4;
  localparam int CfgIndexBits = 8;

  // Register indexes on the configuration channel.
  localparam logic [CfgIndexBits-1:0] RegShortMax  = 8'd0;
  localparam logic [CfgIndexBits-1:0] RegLongHold  = 8'd1;
  localparam logic [CfgIndexBits-1:0] RegRepeatEvery = 8'd2;

  // Reset values of the configuration registers.
  localparam logic [HoldBits-1:0] ShortMaxReset    = 16'd200;
  localparam logic [HoldBits-1:0] LongHoldReset    = 16'd1000;
  localparam logic [RptBits-1:0]  RepeatEveryReset = 4'd5;

  // Beat widths, padded to whole bytes.
  localparam int InDataBits  = ((TimeBits + 1 + 7) / 8) * 8;
  localparam int OutDataBits = 8;

  typedef enum logic [1:0] {
    PH_UP            = 2'd0,
    PH_UNSTABLE_DOWN = 2'd1,
    PH_DOWN          = 2'd2,
    PH_UNSTABLE_UP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } event_t;

  // Scan state carried from one sample to the next.
  typedef struct packed {
    logic                prev_level;
    phase_t              phase;
    logic [TimeBits-1:0] press_stamp;
    logic [RptBits-1:0]  repeat_phase;
  } scan_state_t;

  // Configuration register set.
  typedef struct packed {
    logic [HoldBits-1:0] short_max_ms;
    logic [HoldBits-1:0] long_hold_ms;
    logic [RptBits-1:0]  repeat_every;
  } cfg_t;

endpackage

// ----- design/kcc_fsm.sv -----
module kcc_fsm import kcc_pkg::*; (
  input  scan_state_t         state,
  input  cfg_t                cfg,
  input  logic                key_level,
  input  logic [TimeBits-1:0] now_ms,
  output scan_state_t         state_next,
  output event_t              event_code
);

  logic [TimeBits-1:0] held;
  logic                past_long;
  logic                is_short;
  logic [RptBits-1:0]  period;
  logic [RptBits:0]    rp_inc;
  logic [RptBits-1:0]  rp_adv;
  logic                rise;
  logic                fall;
  logic                both_high;
  logic                both_low;

  // Held time wraps with the time stamp counter.
  assign held      = now_ms - state.press_stamp;
  assign past_long = held > {{(TimeBits-HoldBits){1'b0}}, cfg.long_hold_ms};
  assign is_short  = held <= {{(TimeBits-HoldBits){1'b0}}, cfg.short_max_ms};

  // A repeat period of zero behaves as one.
  assign period = (cfg.repeat_every == '0) ? RptBits'(1) : cfg.repeat_every;
  assign rp_inc = {1'b0, state.repeat_phase} + (RptBits+1)'(1);
  assign rp_adv = (rp_inc >= {1'b0, period}) ? '0 : rp_inc[RptBits-1:0];

  assign rise      = !state.prev_level && key_level;
  assign fall      = state.prev_level && !key_level;
  assign both_high = state.prev_level && key_level;
  assign both_low  = !state.prev_level && !key_level;

  // Next state of the debounce machine and its side registers.
  always_comb begin
    state_next            = state;
    state_next.prev_level = key_level;
    case (state.phase)
      PH_UP: begin
        if (rise) state_next.phase = PH_UNSTABLE_DOWN;
      end
      PH_UNSTABLE_DOWN: begin
        state_next.press_stamp = now_ms;
        state_next.phase       = both_high ? PH_DOWN : PH_UP;
      end
      PH_DOWN: begin
        if (past_long) state_next.repeat_phase = rp_adv;
        if (fall) state_next.phase = PH_UNSTABLE_UP;
      end
      PH_UNSTABLE_UP: begin
        if (both_low) begin
          state_next.phase = PH_UP;
          if (!is_short) state_next.repeat_phase = '0;
        end else begin
          state_next.phase = PH_DOWN;
        end
      end
      default: state_next.phase = PH_UP;
    endcase
  end

  // Event reported for this scan.
  always_comb begin
    event_code = EV_NONE;
    case (state.phase)
      PH_DOWN: begin
        if (past_long && state.repeat_phase == '0) event_code = EV_REPEAT;
      end
      PH_UNSTABLE_UP: begin
        if (both_low) event_code = is_short ? EV_SHORT : EV_LONG;
      end
      default: event_code = EV_NONE;
    endcase
  end

endmodule

// ----- design/key_click_classifier_core.sv -----
// Key click classifier: debounces a scanned push key and classifies clicks.
//
// Input stream (s_*): one beat per key scan, carrying the sampled pin level
// and the current millisecond time stamp. Output stream (m_*): exactly one
// beat per scan, carrying the event code (none, short click, long click,
// long repeat) and the debounce machine state after that scan.
// Configuration channel (cfg_*): writes short_max_ms (index 0), long_hold_ms
// (index 1) and repeat_every (index 2); other indexes are ignored. It is
// always ready and should only be written while no scan is in flight.
//
// The result of a scan is registered: a scan accepted at one edge has its
// result on the output register after that edge. Throughput is one scan per
// cycle while the receiver keeps up, set by the scan state machine update.
// The input stays ready while the output register is empty or being taken,
// so a stalled receiver holds the pending result and back-pressures s_tready.
//
// Reset clears the machine to the up state with no press recorded and loads
// the default registers (200 ms, 1000 ms, a repeat every 5 scans).
module key_click_classifier_core import kcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [InDataBits-1:0]   s_tdata,  // key_level[0], now_ms[32:1], zero pad
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutDataBits-1:0]  m_tdata,  // event_code[1:0], phase_out[3:2], zero pad
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [HoldBits-1:0]     cfg_data
);

  cfg_t        cfg;
  scan_state_t state;
  scan_state_t state_next;
  event_t      ev;
  logic        in_fire;
  logic [1:0]  event_out;
  logic [1:0]  phase_out;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_max_ms <= ShortMaxReset;
      cfg.long_hold_ms <= LongHoldReset;
      cfg.repeat_every <= RepeatEveryReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegShortMax:    cfg.short_max_ms <= cfg_data;
        RegLongHold:    cfg.long_hold_ms <= cfg_data;
        RegRepeatEvery: cfg.repeat_every <= cfg_data[RptBits-1:0];
        default: ;
      endcase
    end
  end

  kcc_fsm u_fsm (
    .state      (state),
    .cfg        (cfg),
    .key_level  (s_tdata[0]),
    .now_ms     (s_tdata[TimeBits:1]),
    .state_next (state_next),
    .event_code (ev)
  );

  // Scan state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.prev_level   <= 1'b0;
      state.phase        <= PH_UP;
      state.press_stamp  <= '0;
      state.repeat_phase <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_out <= ev;
      phase_out <= state_next.phase;
    end
  end

  assign m_tdata = {{(OutDataBits-4){1'b0}}, phase_out, event_out};

endmodule
